// ----- rtl/harmonic_potential_relaxation_defines.svh -----
// Assertion macros used by the checker file of the relaxation block.
`ifndef HARMONIC_POTENTIAL_RELAXATION_DEFINES_SVH
`define HARMONIC_POTENTIAL_RELAXATION_DEFINES_SVH

// Checked only outside reset.
`define HPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define HPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/hpr_pkg.sv -----
// Package of the relaxation block: widths, codes, state type, memory control.
`timescale 1ns / 1ps

package hpr_pkg;

    localparam int LEVEL_W  = 39;
    localparam int POT_W    = 40;
    localparam int RES_W    = 63;
    localparam int CELL_W   = 6;
    localparam int ACC_W    = POT_W + 2;
    localparam int DIFF_W   = POT_W + 1;
    localparam int SQ_IN_W  = 32;
    localparam int CMP_W    = 9;   // holds any grid side up to 256
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 64;
    localparam int STEP_W   = 3;

    localparam int GRID_SIDE_DEF = 64;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(296583680);
    localparam logic [POT_W-1:0]   CLEAR_VALUE = POT_W'(0) - POT_W'(296583680);
    localparam logic [RES_W-1:0]   RES_MAX     = {RES_W{1'b1}};

    localparam logic [PADDR_W-1:0] ADDR_LEVEL = PADDR_W'(0);

    localparam logic FUNC_RELAX = 1'b0;
    localparam logic FUNC_INIT  = 1'b1;

    // read order for one relax: four neighbors, then the cell itself
    localparam logic [STEP_W-1:0] STEP_UP    = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_DOWN  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LEFT  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_RIGHT = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_OLD   = STEP_W'(4);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WAIT,
        S_SQR,
        S_ACC,
        S_WRITE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic we;
    } t_ram_ctl;

endpackage

// ----- rtl/hpr_grid_ram.sv -----
// Single-port grid memory with registered read data.
`timescale 1ns / 1ps

module hpr_grid_ram
    import hpr_pkg::*;
#(
    parameter int DEPTH  = GRID_SIDE_DEF * GRID_SIDE_DEF,
    parameter int ADDR_W = $clog2(GRID_SIDE_DEF * GRID_SIDE_DEF)
) (
    input  logic              i_clk,
    input  t_ram_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [POT_W-1:0]  i_wdata,
    output logic [POT_W-1:0]  o_rdata
);

    logic [POT_W-1:0] r_mem [DEPTH];
    logic [POT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/harmonic_potential_relaxation.sv -----
// Interior relax: four neighbor reads and the cell read on the single grid memory port, a wait step,
// a square step that writes the new value, an accumulate step, then the output step. Border relax:
// cell read, wait, output. Init or obstacle write: write, output. Cell off the grid: output only.
// A stalled result holds the block in its output step until taken; no new request is taken before.
// Reset (i_rst_n low, synchronous) starts a clearing pass over all GRID_SIDE*GRID_SIDE cells
// (4096 at the default) that writes the reset potential; no request is taken until it ends.
`timescale 1ns / 1ps

module harmonic_potential_relaxation
    import hpr_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [CELL_W-1:0]   i_cell_x,
    input  logic [CELL_W-1:0]   i_cell_y,
    input  logic                i_is_obstacle,
    input  logic                i_first_of_sweep,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [POT_W-1:0]    o_potential,
    output logic [RES_W-1:0]    o_residual,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W = $clog2(DEPTH);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_clr;
    logic                r_interior;
    logic [ACC_W-1:0]    r_acc;
    logic [POT_W-1:0]    r_new;
    logic [DIFF_W-1:0]   r_diff;
    logic [RES_W-1:0]    r_sq;
    logic [RES_W-1:0]    r_res;
    logic [POT_W-1:0]    r_pot;
    logic [POT_W-1:0]    r_wdata;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_out_valid;
    logic [POT_W-1:0]    r_out_pot;
    logic [RES_W-1:0]    r_out_res;

    logic [CMP_W-1:0]    w_x, w_y;
    logic                w_in_range, w_interior, w_accept, w_out_load;
    logic [IDX_W-1:0]    w_idx;
    logic [POT_W-1:0]    w_pos_level, w_neg_level;
    logic [POT_W-1:0]    w_rdata, w_mean;
    logic [DIFF_W-1:0]   w_mag;
    logic [2*SQ_IN_W-1:0] w_prod;
    logic [RES_W:0]      w_sum;
    t_ram_ctl            w_ram_ctl;
    logic [IDX_W-1:0]    w_ram_addr;
    logic [POT_W-1:0]    w_ram_wdata;
    logic                w_cfg_wr;

    // ---------------- request decode ----------------
    assign w_x = CMP_W'(i_cell_x);
    assign w_y = CMP_W'(i_cell_y);
    assign w_in_range = (w_x < CMP_W'(GRID_SIDE)) && (w_y < CMP_W'(GRID_SIDE));
    assign w_interior = (w_x != '0) && (w_y != '0) &&
                        (w_x < CMP_W'(GRID_SIDE - 1)) && (w_y < CMP_W'(GRID_SIDE - 1));
    assign w_idx = IDX_W'(IDX_W'(i_cell_x) * IDX_W'(GRID_SIDE)) + IDX_W'(i_cell_y);
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign w_pos_level = POT_W'(r_level);
    assign w_neg_level = POT_W'(0) - POT_W'(r_level);

    // ---------------- arithmetic ----------------
    // floor of sum/4: arithmetic shift of the accumulated neighbors
    assign w_mean = r_acc[ACC_W-1:2];
    assign w_mag  = r_diff[DIFF_W-1] ? (DIFF_W'(0) - r_diff) : r_diff;
    assign w_prod = w_mag[SQ_IN_W-1:0] * w_mag[SQ_IN_W-1:0];
    assign w_sum  = {1'b0, r_res} + {1'b0, r_sq};

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == IDX_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_in_range) begin
                        n_state = S_OUT;
                    end else if ((i_func == FUNC_INIT) || i_is_obstacle) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_step == STEP_OLD) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = r_interior ? S_SQR : S_OUT;
            end
            S_SQR:   n_state = S_ACC;
            S_ACC:   n_state = S_OUT;
            S_WRITE: n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- memory port and handshake ----------------
    always_comb begin
        w_ram_ctl   = '{en: 1'b0, we: 1'b0};
        w_ram_addr  = r_idx;
        w_ram_wdata = r_new;
        case (r_state)
            S_CLEAR: begin
                w_ram_ctl   = '{en: 1'b1, we: 1'b1};
                w_ram_addr  = r_clr;
                w_ram_wdata = CLEAR_VALUE;
            end
            S_RD: begin
                w_ram_ctl = '{en: 1'b1, we: 1'b0};
                case (r_step)
                    STEP_UP:    w_ram_addr = r_idx - IDX_W'(GRID_SIDE);
                    STEP_DOWN:  w_ram_addr = r_idx + IDX_W'(GRID_SIDE);
                    STEP_LEFT:  w_ram_addr = r_idx - IDX_W'(1);
                    STEP_RIGHT: w_ram_addr = r_idx + IDX_W'(1);
                    default:    w_ram_addr = r_idx;
                endcase
            end
            S_WRITE: begin
                w_ram_ctl   = '{en: 1'b1, we: 1'b1};
                w_ram_wdata = r_wdata;
            end
            S_SQR: begin
                w_ram_ctl = '{en: 1'b1, we: 1'b1};
            end
            default: begin
                w_ram_ctl = '{en: 1'b0, we: 1'b0};
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    hpr_grid_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_ram_ctl),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rdata)
    );

    // ---------------- control registers ----------------
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_LEVEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_level     <= LEVEL_RESET;
            r_res       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (w_cfg_wr) begin
                r_level <= pwdata[LEVEL_W-1:0];
            end
            if (w_accept && i_first_of_sweep) begin
                r_res <= '0;
            end else if (r_state == S_ACC) begin
                r_res <= w_sum[RES_W] ? RES_MAX : w_sum[RES_W-1:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx      <= w_idx;
                r_interior <= w_interior;
                r_acc      <= '0;
                r_pot      <= '0;
                r_step     <= w_interior ? STEP_UP : STEP_OLD;
                r_wdata    <= (i_func == FUNC_INIT) ? w_neg_level : w_pos_level;
            end
            S_RD: begin
                r_step <= r_step + STEP_W'(1);
                // data of the previous step's read is on the port now
                if (r_step != STEP_UP) begin
                    r_acc <= r_acc + {{(ACC_W - POT_W){w_rdata[POT_W-1]}}, w_rdata};
                end
            end
            S_WAIT: begin
                r_new  <= w_mean;
                r_diff <= {w_mean[POT_W-1], w_mean} - {w_rdata[POT_W-1], w_rdata};
                r_pot  <= w_rdata;
            end
            S_SQR: begin
                r_pot <= r_new;
                if ((w_mag[DIFF_W-1:SQ_IN_W] != '0) || w_prod[2*SQ_IN_W-1]) begin
                    r_sq <= RES_MAX;
                end else begin
                    r_sq <= w_prod[RES_W-1:0];
                end
            end
            S_WRITE: begin
                r_pot <= r_wdata;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
        if (w_out_load) begin
            r_out_pot <= r_pot;
            r_out_res <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_potential = r_out_pot;
    assign o_residual  = r_out_res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LEVEL) ? PDATA_W'(r_level) : '0;

endmodule

// ----- rtl/hpr_checker.sv -----
// Port-level checker of the relaxation block and its bind.
`timescale 1ns / 1ps
`include "harmonic_potential_relaxation_defines.svh"

module hpr_checker
    import hpr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [POT_W-1:0]    o_potential,
    input logic [RES_W-1:0]    o_residual
);

    // a taken request keeps the block busy for at least the next cycle
    `HPR_ASSERT(a_busy_after_req, i_in_valid && !o_in_stall |=> o_in_stall, "accepted back to back")

    `HPR_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_potential) && $stable(o_residual), "stalled result changed")

    // the clearing pass follows reset
    `HPR_ASSERT_ALWAYS(a_clear_after_rst, !i_rst_n |=> o_in_stall, "request taken during clear")

endmodule

bind harmonic_potential_relaxation hpr_checker u_hpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_potential (o_potential),
    .o_residual  (o_residual)
);
